### rtl/core/c420ds_pkg.sv
// ----------------------------------------------------------------------------
// c420ds_pkg
// Shared constants and types of the 4:2:0 chroma downsampler.
// ----------------------------------------------------------------------------
package c420ds_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int SLOT_BITS   = $clog2(STORE_DEPTH);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int DIM_BITS    = 12;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);
   localparam logic [DIM_BITS-1:0] WIDTH_LIMIT  = DIM_BITS'(MAX_WIDTH);

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // one line store entry: upper pair of a 2x2 block
   typedef struct packed {
      logic [7:0] luma_tl;
      logic [7:0] luma_tr;
      logic [8:0] cb_sum;
      logic [8:0] cr_sum;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // lower pair of a block, handed from position control to the merge stage
   typedef struct packed {
      logic       valid;
      logic [7:0] luma_bl;
      logic [7:0] luma_br;
      logic [8:0] cb_sum;
      logic [8:0] cr_sum;
      logic       frame_done;
   } lower_type;

endpackage

### rtl/core/c420ds_if.sv
// ----------------------------------------------------------------------------
// c420ds_if
// Pixel and block channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface c420ds_pix_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma;
   logic [7:0] chroma_blue;
   logic [7:0] chroma_red;

   modport source (output valid, output luma, output chroma_blue, output chroma_red,
                   input ready);
   modport sink (input valid, input luma, input chroma_blue, input chroma_red,
                 output ready);
endinterface

interface c420ds_blk_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_top_left;
   logic [7:0] luma_top_right;
   logic [7:0] luma_bottom_left;
   logic [7:0] luma_bottom_right;
   logic [7:0] blue_average;
   logic [7:0] red_average;
   logic       frame_done;

   modport source (output valid, output luma_top_left, output luma_top_right,
                   output luma_bottom_left, output luma_bottom_right,
                   output blue_average, output red_average, output frame_done,
                   input ready);
   modport sink (input valid, input luma_top_left, input luma_top_right,
                 input luma_bottom_left, input luma_bottom_right,
                 input blue_average, input red_average, input frame_done,
                 output ready);
endinterface

### rtl/core/c420ds_ram.sv
// ----------------------------------------------------------------------------
// c420ds_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module c420ds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/c420ds_ctrl.sv
// ----------------------------------------------------------------------------
// c420ds_ctrl
// Frame position counters, size registers, left pixel hold and line store
// access for each accepted pixel.
// ----------------------------------------------------------------------------
module c420ds_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   c420ds_pix_if.sink                              pix,
   input  logic                                    take_ok,
   input  logic                                    csr_write_enable,
   input  logic [c420ds_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [c420ds_pkg::DIM_BITS-1:0]         csr_write_data,
   output logic                                    store_wr_en,
   output logic [c420ds_pkg::SLOT_BITS-1:0]        store_addr,
   output c420ds_pkg::entry_type                   store_wr_data,
   output logic                                    store_rd_en,
   output c420ds_pkg::lower_type                   lower
);

   logic [c420ds_pkg::DIM_BITS-1:0] width_ff, width_in;
   logic [c420ds_pkg::DIM_BITS-1:0] height_ff, height_in;
   logic [c420ds_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [c420ds_pkg::DIM_BITS-1:0] row_ff, row_in;
   logic [23:0]                     left_ff, left_in;

   logic                            accept;
   logic [c420ds_pkg::DIM_BITS-1:0] eff_width;
   logic [c420ds_pkg::DIM_BITS-1:0] col_wide;
   logic [c420ds_pkg::DIM_BITS:0]   row_next1;
   logic [c420ds_pkg::DIM_BITS:0]   row_next2;
   logic [c420ds_pkg::DIM_BITS:0]   col_next2;
   logic                            row_end;
   logic [7:0]                      left_y, left_cb, left_cr;

   assign accept    = pix.valid && take_ok;
   assign pix.ready = take_ok;

   assign eff_width = (width_ff > c420ds_pkg::WIDTH_LIMIT) ? c420ds_pkg::WIDTH_LIMIT
                                                           : width_ff;
   assign col_wide  = c420ds_pkg::DIM_BITS'(col_ff);
   assign col_next2 = {1'b0, col_wide} + 13'd2;
   assign row_next1 = {1'b0, row_ff} + 13'd1;
   assign row_next2 = {1'b0, row_ff} + 13'd2;
   assign row_end   = (({1'b0, col_wide} + 13'd1) >= {1'b0, eff_width});

   assign left_y  = left_ff[23:16];
   assign left_cb = left_ff[15:8];
   assign left_cr = left_ff[7:0];

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            c420ds_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            c420ds_pkg::CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // position counters and left pixel hold
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (!col_ff[0]) begin
            left_in = {pix.luma, pix.chroma_blue, pix.chroma_red};
         end
         if (row_end) begin
            col_in = '0;
            row_in = (row_next1 >= {1'b0, height_ff}) ? '0
                                                        : row_next1[c420ds_pkg::DIM_BITS-1:0];
         end else begin
            col_in = col_ff + c420ds_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= c420ds_pkg::WIDTH_RESET;
         height_ff <= c420ds_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
      end
   end

   // odd column closes a pair: even row stores it, odd row fetches the upper pair
   assign store_addr    = col_ff[c420ds_pkg::COL_BITS-1:1];
   assign store_wr_en   = accept && col_ff[0] && !row_ff[0];
   assign store_rd_en   = accept && col_ff[0] && row_ff[0];

   assign store_wr_data.luma_tl = left_y;
   assign store_wr_data.luma_tr = pix.luma;
   assign store_wr_data.cb_sum  = {1'b0, left_cb} + {1'b0, pix.chroma_blue};
   assign store_wr_data.cr_sum  = {1'b0, left_cr} + {1'b0, pix.chroma_red};

   assign lower.valid      = store_rd_en;
   assign lower.luma_bl    = left_y;
   assign lower.luma_br    = pix.luma;
   assign lower.cb_sum     = store_wr_data.cb_sum;
   assign lower.cr_sum     = store_wr_data.cr_sum;
   assign lower.frame_done = (col_next2 >= {1'b0, eff_width}) &&
                             (row_next2 >= {1'b0, height_ff});

endmodule

### rtl/core/c420ds_merge.sv
// ----------------------------------------------------------------------------
// c420ds_merge
// Joins the fetched upper pair with the lower pair, forms the chroma
// averages and holds the block in the output register.
// ----------------------------------------------------------------------------
module c420ds_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  c420ds_pkg::lower_type  lower,
   input  c420ds_pkg::entry_type  upper,
   output logic                   take_ok,
   c420ds_blk_if.source           blk
);

   logic                  s1_valid_ff, s1_valid_in;
   c420ds_pkg::lower_type s1_ff, s1_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            tl_ff, tl_in, tr_ff, tr_in, bl_ff, bl_in, br_ff, br_in;
   logic [7:0]            cb_ff, cb_in, cr_ff, cr_in;
   logic                  done_ff, done_in;

   logic                  out_free;
   logic [9:0]            cb_total, cr_total;

   assign out_free = !out_valid_ff || blk.ready;
   assign take_ok  = !s1_valid_ff || out_free;

   assign cb_total = {1'b0, upper.cb_sum} + {1'b0, s1_ff.cb_sum};
   assign cr_total = {1'b0, upper.cr_sum} + {1'b0, s1_ff.cr_sum};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (take_ok) begin
         s1_valid_in = lower.valid;
         s1_in       = lower;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      tl_in   = tl_ff;
      tr_in   = tr_ff;
      bl_in   = bl_ff;
      br_in   = br_ff;
      cb_in   = cb_ff;
      cr_in   = cr_ff;
      done_in = done_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         tl_in   = upper.luma_tl;
         tr_in   = upper.luma_tr;
         bl_in   = s1_ff.luma_bl;
         br_in   = s1_ff.luma_br;
         cb_in   = cb_total[9:2];
         cr_in   = cr_total[9:2];
         done_in = s1_ff.frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= s1_in;
      tl_ff   <= tl_in;
      tr_ff   <= tr_in;
      bl_ff   <= bl_in;
      br_ff   <= br_in;
      cb_ff   <= cb_in;
      cr_ff   <= cr_in;
      done_ff <= done_in;
   end

   assign blk.valid             = out_valid_ff;
   assign blk.luma_top_left     = tl_ff;
   assign blk.luma_top_right    = tr_ff;
   assign blk.luma_bottom_left  = bl_ff;
   assign blk.luma_bottom_right = br_ff;
   assign blk.blue_average      = cb_ff;
   assign blk.red_average       = cr_ff;
   assign blk.frame_done        = done_ff;

endmodule

### rtl/core/chroma_420_downsampler.sv
// Throughput: one pixel per cycle while the block output is not stalled; an odd-column
// pixel writes or reads the line store, an even-column pixel does neither.
// Block path: line store read and lower pair register, then the output register on rsp.
// Reset: synchronous; counters and left pixel hold clear, size returns to 640 x 480,
// line store contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// chroma_420_downsampler
// 4:2:0 chroma subsampling of a raster YCbCr stream, one result per 2x2 block.
// ----------------------------------------------------------------------------
module chroma_420_downsampler (
   input  logic                                clock,
   input  logic                                reset,
   c420ds_pix_if.sink                          req_channel,
   c420ds_blk_if.source                        rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [c420ds_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [c420ds_pkg::DIM_BITS-1:0]     csr_write_data
);

   logic                                 take_ok;
   logic                                 store_wr_en;
   logic                                 store_rd_en;
   logic [c420ds_pkg::SLOT_BITS-1:0]     store_addr;
   c420ds_pkg::entry_type                store_wr_data;
   logic [c420ds_pkg::ENTRY_BITS-1:0]    store_rd_bits;
   c420ds_pkg::entry_type                upper;
   c420ds_pkg::lower_type                lower;

   c420ds_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .pix              (req_channel),
      .take_ok          (take_ok),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .store_wr_en      (store_wr_en),
      .store_addr       (store_addr),
      .store_wr_data    (store_wr_data),
      .store_rd_en      (store_rd_en),
      .lower            (lower)
   );

   c420ds_ram #(
      .WIDTH (c420ds_pkg::ENTRY_BITS),
      .DEPTH (c420ds_pkg::STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_addr),
      .rd_data (store_rd_bits)
   );

   assign upper = store_rd_bits;

   c420ds_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .lower   (lower),
      .upper   (upper),
      .take_ok (take_ok),
      .blk     (rsp_channel)
   );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4:2:0 chroma downsampler. Streams raster pixels
// through frames of many sizes (default size after reset, odd and degenerate
// sizes, resizes in the middle of a frame), predicts every 2x2 block and
// checks each block transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS   = 1000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned IDLE_SETTLE    = 4;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } pixel_type;

   typedef struct packed {
      logic [7:0] top_left;
      logic [7:0] top_right;
      logic [7:0] bottom_left;
      logic [7:0] bottom_right;
      logic [7:0] blue_average;
      logic [7:0] red_average;
      logic       frame_done;
   } block_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable;
   logic [c420ds_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [c420ds_pkg::DIM_BITS-1:0]     csr_write_data;

   c420ds_pix_if pixel_ch ();
   c420ds_blk_if block_ch ();

   chroma_420_downsampler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (pixel_ch.sink),
      .rsp_channel      (block_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [c420ds_pkg::DIM_BITS-1:0] frame_width  = 12'd640;
   logic [c420ds_pkg::DIM_BITS-1:0] frame_height = 12'd480;
   int unsigned                     next_column  = 0;
   int unsigned                     next_row     = 0;
   pixel_type                       held_left    = '0;
   c420ds_pkg::entry_type           upper_pairs [c420ds_pkg::STORE_DEPTH];

   block_type   pending_blocks [$];
   int unsigned mismatch_count  = 0;
   int unsigned pixels_sent     = 0;
   bit          sender_gaps     = 1'b1;
   bit          receiver_stalls = 1'b1;
   bit          hold_request    = 1'b0;

   function automatic void downsample_pixel(input pixel_type p);
      int unsigned           eff_width;
      int unsigned           slot;
      logic [9:0]            cb_total;
      logic [9:0]            cr_total;
      c420ds_pkg::entry_type upper;
      block_type             blk;
      eff_width = (frame_width > c420ds_pkg::WIDTH_LIMIT) ? c420ds_pkg::MAX_WIDTH
                                                          : frame_width;
      slot = next_column >> 1;
      if (next_column[0] == 1'b0) begin
         held_left = p;
      end else if (next_row[0] == 1'b0) begin
         upper.luma_tl = held_left.luma;
         upper.luma_tr = p.luma;
         upper.cb_sum  = 9'(held_left.chroma_blue) + 9'(p.chroma_blue);
         upper.cr_sum  = 9'(held_left.chroma_red) + 9'(p.chroma_red);
         upper_pairs[slot] = upper;
      end else begin
         upper = upper_pairs[slot];
         cb_total = 10'(upper.cb_sum) + 10'(held_left.chroma_blue) + 10'(p.chroma_blue);
         cr_total = 10'(upper.cr_sum) + 10'(held_left.chroma_red) + 10'(p.chroma_red);
         blk.top_left     = upper.luma_tl;
         blk.top_right    = upper.luma_tr;
         blk.bottom_left  = held_left.luma;
         blk.bottom_right = p.luma;
         blk.blue_average = cb_total[9:2];
         blk.red_average  = cr_total[9:2];
         blk.frame_done   = (next_column + 2 >= eff_width) && (next_row + 2 >= frame_height);
         pending_blocks.push_back(blk);
      end
      // a size of zero or one keeps the counter at zero
      if (next_column + 1 >= eff_width) begin
         next_column = 0;
         next_row = (next_row + 1 >= frame_height) ? 0 : next_row + 1;
      end else begin
         next_column++;
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p = 24'($urandom);
      if ($urandom_range(0, 7) == 0) p.luma = {8{p.luma[0]}};
      if ($urandom_range(0, 7) == 0) p.chroma_blue = {8{p.chroma_blue[0]}};
      if ($urandom_range(0, 7) == 0) p.chroma_red = {8{p.chroma_red[0]}};
      return p;
   endfunction

   // every task starts and ends on a falling edge
   task automatic send_pixel(input pixel_type p);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         pixel_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      pixel_ch.valid       <= 1'b1;
      pixel_ch.luma        <= p.luma;
      pixel_ch.chroma_blue <= p.chroma_blue;
      pixel_ch.chroma_red  <= p.chroma_red;
      @(posedge clock);
      while (pixel_ch.ready !== 1'b1) @(posedge clock);
      downsample_pixel(p);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      pixel_ch.valid <= 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      // pixels that give no block may still be in the pipeline
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_register(input logic [c420ds_pkg::CSR_IDX_BITS-1:0] idx,
                                 input logic [c420ds_pkg::DIM_BITS-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      if (idx == c420ds_pkg::CSR_IMAGE_WIDTH) frame_width = value;
      else frame_height = value;
   endtask

   task automatic set_frame_size(input logic [c420ds_pkg::DIM_BITS-1:0] w,
                                 input logic [c420ds_pkg::DIM_BITS-1:0] h);
      write_register(c420ds_pkg::CSR_IMAGE_WIDTH, w);
      write_register(c420ds_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic align_frame();
      while (next_column != 0 || next_row != 0) send_pixel(random_pixel());
   endtask

   task automatic test_reset_size();
      // one row at the 640 x 480 default, then the first blocks of the next row
      repeat (644) send_pixel(random_pixel());
      set_frame_size(12'd2, 12'd2);
      align_frame();
   endtask

   task automatic test_extreme_values();
      set_frame_size(12'd2, 12'd2);
      repeat (4) send_pixel('{8'h00, 8'h00, 8'h00});
      repeat (4) send_pixel('{8'hFF, 8'hFF, 8'hFF});
      // truncating averages: Cb sum 3, Cr sum 1019
      send_pixel('{8'h01, 8'h00, 8'hFF});
      send_pixel('{8'h02, 8'h00, 8'hFF});
      send_pixel('{8'h03, 8'h01, 8'hFF});
      send_pixel('{8'h04, 8'h02, 8'hFE});
      send_pixel('{8'hAA, 8'h55, 8'hAA});
      send_pixel('{8'h55, 8'hAA, 8'h55});
      send_pixel('{8'hAA, 8'h55, 8'hAA});
      send_pixel('{8'h55, 8'hAA, 8'h55});
      send_pixel('{8'h80, 8'hFF, 8'h00});
      send_pixel('{8'h7F, 8'h00, 8'hFF});
      send_pixel('{8'h01, 8'h00, 8'h00});
      send_pixel('{8'hFE, 8'h00, 8'h00});
   endtask

   task automatic test_odd_sizes();
      // trailing column and row never complete a block
      set_frame_size(12'd5, 12'd5);
      repeat (25) send_pixel(random_pixel());
      set_frame_size(12'd3, 12'd3);
      repeat (9) send_pixel(random_pixel());
      set_frame_size(12'd2, 12'd3);
      repeat (6) send_pixel(random_pixel());
      set_frame_size(12'd7, 12'd2);
      repeat (14) send_pixel(random_pixel());
   endtask

   task automatic test_degenerate_sizes();
      set_frame_size(12'd0, 12'd3);
      repeat (7) send_pixel(random_pixel());
      set_frame_size(12'd1, 12'd2);
      repeat (5) send_pixel(random_pixel());
      set_frame_size(12'd6, 12'd0);
      repeat (9) send_pixel(random_pixel());
      set_frame_size(12'd6, 12'd1);
      repeat (9) send_pixel(random_pixel());
      set_frame_size(12'd4, 12'd2);
      align_frame();
   endtask

   task automatic test_midframe_resize();
      set_frame_size(12'd2, 12'hFFF);
      repeat (40) send_pixel(random_pixel());
      // row is past the new height: wraps at the end of the current row
      write_register(c420ds_pkg::CSR_IMAGE_HEIGHT, 12'd2);
      align_frame();
      set_frame_size(12'd8, 12'd4);
      repeat (12) send_pixel(random_pixel());
      write_register(c420ds_pkg::CSR_IMAGE_WIDTH, 12'd4);
      align_frame();
   endtask

   task automatic test_backpressure();
      set_frame_size(12'd2, 12'd2);
      sender_gaps  = 1'b0;
      hold_request = 1'b1;
      repeat (80) send_pixel(random_pixel());
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned start;
      int unsigned kind;
      int unsigned w;
      int unsigned h;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_ITEMS) begin
         if (pixels_sent - start >= RANDOM_ITEMS * 5 / 6) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end else begin
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
         end
         kind = $urandom_range(0, 19);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
         h = (w > 12) ? $urandom_range(2, 3) : $urandom_range(2, 7);
         if (kind < 15) begin
            // back-to-back frames when the size is kept
            if ($urandom_range(0, 2) != 0) begin
               set_frame_size(c420ds_pkg::DIM_BITS'(w), c420ds_pkg::DIM_BITS'(h));
            end
            repeat (frame_width * frame_height) send_pixel(random_pixel());
         end else if (kind < 18) begin
            set_frame_size(c420ds_pkg::DIM_BITS'(w), c420ds_pkg::DIM_BITS'(h));
            repeat ($urandom_range(1, w * h - 1)) send_pixel(random_pixel());
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 6);
            case ($urandom_range(0, 2))
               0: write_register(c420ds_pkg::CSR_IMAGE_WIDTH, c420ds_pkg::DIM_BITS'(w));
               1: write_register(c420ds_pkg::CSR_IMAGE_HEIGHT, c420ds_pkg::DIM_BITS'(h));
               default: set_frame_size(c420ds_pkg::DIM_BITS'(w), c420ds_pkg::DIM_BITS'(h));
            endcase
            align_frame();
         end else begin
            if ($urandom_range(0, 1)) begin
               set_frame_size(c420ds_pkg::DIM_BITS'($urandom_range(0, 1)),
                              c420ds_pkg::DIM_BITS'($urandom_range(2, 5)));
            end else begin
               set_frame_size(c420ds_pkg::DIM_BITS'($urandom_range(2, 12)),
                              c420ds_pkg::DIM_BITS'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(1, 10)) send_pixel(random_pixel());
            set_frame_size(c420ds_pkg::DIM_BITS'(w), c420ds_pkg::DIM_BITS'(h));
            align_frame();
         end
      end
   endtask

   always @(posedge clock) begin : block_checker
      block_type want;
      if (!reset && block_ch.valid === 1'b1 && block_ch.ready === 1'b1) begin
         if (pending_blocks.size() == 0) begin
            $error("block transfer with none expected: luma_top_left %0d, frame_done %0d",
                   block_ch.luma_top_left, block_ch.frame_done);
            mismatch_count++;
         end else begin
            want = pending_blocks.pop_front();
            check_field("luma_top_left", want.top_left, block_ch.luma_top_left);
            check_field("luma_top_right", want.top_right, block_ch.luma_top_right);
            check_field("luma_bottom_left", want.bottom_left, block_ch.luma_bottom_left);
            check_field("luma_bottom_right", want.bottom_right, block_ch.luma_bottom_right);
            check_field("blue_average", want.blue_average, block_ch.blue_average);
            check_field("red_average", want.red_average, block_ch.red_average);
            check_field("frame_done", 8'(want.frame_done), 8'(block_ch.frame_done));
         end
      end
   end

   initial begin : block_receiver
      int unsigned stall;
      stall = 0;
      block_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && receiver_stalls && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 5);
         end
         if (stall != 0) begin
            block_ch.ready <= 1'b0;
            stall--;
         end else begin
            block_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) ||
             (block_ch.valid === 1'b1 && block_ch.ready === 1'b1)) quiet = 0;
         else quiet++;
      end
      $display("chroma_420_downsampler test failed");
      $finish;
   end

   initial begin : test_sequence
      pixel_ch.valid       <= 1'b0;
      pixel_ch.luma        <= '0;
      pixel_ch.chroma_blue <= '0;
      pixel_ch.chroma_red  <= '0;
      csr_write_enable     <= 1'b0;
      csr_index            <= c420ds_pkg::CSR_IMAGE_WIDTH;
      csr_write_data       <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_size();
      test_extreme_values();
      test_odd_sizes();
      test_degenerate_sizes();
      test_midframe_resize();
      test_backpressure();
      test_random_frames();
      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("chroma_420_downsampler test passed");
      end else begin
         $display("chroma_420_downsampler test failed");
      end
      $finish;
   end

endmodule

### chroma_420_downsampler.f
rtl/core/c420ds_pkg.sv
rtl/core/c420ds_if.sv
rtl/core/c420ds_ram.sv
rtl/core/c420ds_ctrl.sv
rtl/core/c420ds_merge.sv
rtl/core/chroma_420_downsampler.sv
test/tb_top.sv
